/* rtl/core/slbm_pkg.sv */
// Shared types, constants and codes for the serial loaded bank mapper.
package slbm_pkg;

    localparam int REG_W = 5;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int PRG_W = 6;
    localparam int CHR_W = 9;
    localparam int MIRROR_W = 2;
    localparam int PRG_CNT_W = 7;
    localparam int CHR_CNT_W = 8;
    localparam int CART_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_W = 7;
    localparam int REM_W = 9;
    localparam int STEP_CNT_W = $clog2(NUM_W);
    localparam int BIT_CNT_W = 3;
    localparam int PS_W = 6;

    localparam int PRG_PAGE_LIMIT = 64;

    localparam int SEL_LO = 13;
    localparam int SEL_HI = 14;
    localparam int LOADER_RESET_BIT = 7;
    localparam int SERIAL_BIT = 0;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 3'd4;
    localparam logic [REG_W-1:0] CTRL_RESET_BITS = 5'h0C;
    localparam logic [NUM_W-1:0] FIXED_HIGH_BANK = 7'h0F;
    localparam logic [PS_W-1:0] OUTER_BOTH = 6'h30;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_PAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE = 2'd3;

    localparam logic [CART_W-1:0] CART_512K = 2'd1;
    localparam logic [CART_W-1:0] CART_1024K = 2'd2;

    localparam int CTRL_PRG_SIZE_BIT = 3;
    localparam int CTRL_PRG_SLOT_BIT = 2;
    localparam int CTRL_CHR_MODE_BIT = 4;
    localparam int OUTER_BIT = 4;

    typedef enum logic [1:0] {
        SEL_CONTROL,
        SEL_CHR0,
        SEL_CHR1,
        SEL_PRG
    } reg_sel_t;

    typedef enum logic [1:0] {
        OP_PRG_LO,
        OP_PRG_HI,
        OP_CHR_LO,
        OP_CHR_HI
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [REG_W-1:0] control;
        logic [REG_W-1:0] chr0;
        logic [REG_W-1:0] chr1;
        logic [REG_W-1:0] prg;
    } mregs_t;

    typedef struct packed {
        logic [PRG_CNT_W-1:0] prg_pages;
        logic [CHR_CNT_W-1:0] chr_pages;
        logic                 chr_present;
        logic [CART_W-1:0]    size_mode;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numerator;
        logic [REM_W-1:0] modulus;
    } mod_req_t;

endpackage

/* rtl/core/slbm_loader.sv */
// Serial shift loader and the four mapper registers.
module slbm_loader (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_en,
    input  logic [slbm_pkg::ADDR_W-1:0]   cpu_address,
    input  logic [slbm_pkg::DATA_W-1:0]   data_byte,
    output logic                          commit,
    output slbm_pkg::mregs_t              regs
);
    import slbm_pkg::*;

    mregs_t                regs_reg, regs_next;
    logic [REG_W-1:0]      buf_reg, buf_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BIT_CNT_W-1:0]  idx;
    logic [REG_W-1:0]      new_buf;
    reg_sel_t              sel;

    always_comb begin
        sel = reg_sel_t'(cpu_address[SEL_HI:SEL_LO]);
        idx = (cnt_reg > LAST_BIT_IDX) ? LAST_BIT_IDX : cnt_reg;
        new_buf = buf_reg | (REG_W'(data_byte[SERIAL_BIT]) << idx);
        commit = data_byte[LOADER_RESET_BIT] || (idx == LAST_BIT_IDX);
        regs_next = regs_reg;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load_en) begin
            if (data_byte[LOADER_RESET_BIT]) begin
                regs_next.control = regs_reg.control | CTRL_RESET_BITS;
                buf_next = '0;
                cnt_next = '0;
            end else if (idx == LAST_BIT_IDX) begin
                case (sel)
                    SEL_CONTROL: regs_next.control = new_buf;
                    SEL_CHR0:    regs_next.chr0 = new_buf;
                    SEL_CHR1:    regs_next.chr1 = new_buf;
                    SEL_PRG:     regs_next.prg = new_buf;
                    default:     regs_next = regs_reg;
                endcase
                buf_next = '0;
                cnt_next = '0;
            end else begin
                buf_next = new_buf;
                cnt_next = idx + BIT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
            buf_reg <= '0;
            cnt_reg <= '0;
        end else begin
            regs_reg <= regs_next;
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

    assign regs = regs_reg;

endmodule

/* rtl/core/slbm_mod_unit.sv */
// Iterative restoring remainder unit, one numerator bit per cycle.
module slbm_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  slbm_pkg::mod_req_t          req,
    output logic                        done,
    output logic [slbm_pkg::REM_W-1:0]  rem
);
    import slbm_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  zero_reg, zero_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [REM_W-1:0]      mod_reg, mod_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [REM_W:0]        shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        mod_next = mod_reg;
        rem_next = rem_reg;
        shifted = {rem_reg, num_reg[NUM_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            zero_next = (req.modulus == '0);
            cnt_next = STEP_CNT_W'(NUM_W - 1);
            num_next = req.numerator;
            mod_next = req.modulus;
            rem_next = '0;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, mod_reg}) begin
                rem_next = REM_W'(shifted - {1'b0, mod_reg});
            end else begin
                rem_next = shifted[REM_W-1:0];
            end
            num_next = num_reg << 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - STEP_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        zero_reg <= zero_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        mod_reg <= mod_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem = zero_reg ? '0 : rem_reg;

endmodule

/* rtl/core/slbm_sequencer.sv */
// Sequencer that derives the banks through the shared remainder unit and holds the result.
module slbm_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           commit,
    input  slbm_pkg::mregs_t               regs,
    input  slbm_pkg::cfg_t                 cfg,
    output slbm_pkg::mod_req_t             mod_req,
    input  logic                           mod_done,
    input  logic [slbm_pkg::REM_W-1:0]     mod_rem,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_mapping_updated,
    output logic [slbm_pkg::PRG_W-1:0]     m_prg_bank_low,
    output logic [slbm_pkg::PRG_W-1:0]     m_prg_bank_high,
    output logic [slbm_pkg::CHR_W-1:0]     m_chr_bank_low,
    output logic [slbm_pkg::CHR_W-1:0]     m_chr_bank_high,
    output logic [slbm_pkg::MIRROR_W-1:0]  m_mirroring_mode
);
    import slbm_pkg::*;

    seq_state_t           state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 commit_reg, commit_next;
    logic [PRG_W-1:0]     prg_lo_reg, prg_lo_next;
    logic [PRG_W-1:0]     prg_hi_reg, prg_hi_next;
    logic [CHR_W-1:0]     chr_lo_reg, chr_lo_next;
    logic [CHR_W-1:0]     chr_hi_reg, chr_hi_next;
    logic [MIRROR_W-1:0]  mirror_reg, mirror_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_upd_reg, out_upd_next;
    logic [PRG_W-1:0]     out_prg_lo_reg, out_prg_lo_next;
    logic [PRG_W-1:0]     out_prg_hi_reg, out_prg_hi_next;
    logic [CHR_W-1:0]     out_chr_lo_reg, out_chr_lo_next;
    logic [CHR_W-1:0]     out_chr_hi_reg, out_chr_hi_next;
    logic [MIRROR_W-1:0]  out_mirror_reg, out_mirror_next;

    logic [PS_W-1:0]      ps;
    logic [PRG_CNT_W-1:0] pages;
    logic [NUM_W-1:0]     base32;
    logic [NUM_W-1:0]     reg_bank;
    logic [NUM_W-1:0]     fixed_bank;
    logic [REM_W-1:0]     prg_modulus;
    logic [REM_W-1:0]     chr_modulus;

    always_comb begin
        case (cfg.size_mode)
            CART_512K: ps = {1'b0, regs.chr0[OUTER_BIT], 4'b0000};
            CART_1024K: begin
                if (regs.control[CTRL_CHR_MODE_BIT]) begin
                    ps = {regs.chr1[OUTER_BIT], regs.chr0[OUTER_BIT], 4'b0000};
                end else begin
                    ps = regs.chr0[OUTER_BIT] ? OUTER_BOTH : '0;
                end
            end
            default: ps = '0;
        endcase
        pages = (cfg.prg_pages > PRG_CNT_W'(PRG_PAGE_LIMIT)) ?
                PRG_CNT_W'(PRG_PAGE_LIMIT) : cfg.prg_pages;
        prg_modulus = REM_W'(pages);
        chr_modulus = {cfg.chr_pages, 1'b0};
        base32 = NUM_W'({regs.prg[REG_W-1:1], 1'b0}) + NUM_W'(ps);
        reg_bank = NUM_W'(regs.prg) + NUM_W'(ps);
        fixed_bank = FIXED_HIGH_BANK + NUM_W'(ps);

        mod_req.start = 1'b0;
        case (op_reg)
            OP_PRG_LO: begin
                mod_req.modulus = prg_modulus;
                if (!regs.control[CTRL_PRG_SIZE_BIT]) begin
                    mod_req.numerator = base32;
                end else if (regs.control[CTRL_PRG_SLOT_BIT]) begin
                    mod_req.numerator = reg_bank;
                end else begin
                    mod_req.numerator = '0;
                end
            end
            OP_PRG_HI: begin
                mod_req.modulus = prg_modulus;
                if (!regs.control[CTRL_PRG_SIZE_BIT]) begin
                    mod_req.numerator = base32 + NUM_W'(1);
                end else if (regs.control[CTRL_PRG_SLOT_BIT]) begin
                    mod_req.numerator = fixed_bank;
                end else begin
                    mod_req.numerator = reg_bank;
                end
            end
            OP_CHR_LO: begin
                mod_req.modulus = chr_modulus;
                mod_req.numerator = NUM_W'(regs.chr0);
            end
            OP_CHR_HI: begin
                mod_req.modulus = chr_modulus;
                mod_req.numerator = NUM_W'(regs.chr1);
            end
            default: begin
                mod_req.modulus = prg_modulus;
                mod_req.numerator = '0;
            end
        endcase

        state_next = state_reg;
        op_next = op_reg;
        commit_next = commit_reg;
        prg_lo_next = prg_lo_reg;
        prg_hi_next = prg_hi_reg;
        chr_lo_next = chr_lo_reg;
        chr_hi_next = chr_hi_reg;
        mirror_next = mirror_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_upd_next = out_upd_reg;
        out_prg_lo_next = out_prg_lo_reg;
        out_prg_hi_next = out_prg_hi_reg;
        out_chr_lo_next = out_chr_lo_reg;
        out_chr_hi_next = out_chr_hi_reg;
        out_mirror_next = out_mirror_reg;
        s_ready = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    commit_next = commit;
                    op_next = OP_PRG_LO;
                    state_next = commit ? ST_START : ST_DONE;
                end
            end
            ST_START: begin
                mod_req.start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mod_done) begin
                    case (op_reg)
                        OP_PRG_LO: prg_lo_next = mod_rem[PRG_W-1:0];
                        OP_PRG_HI: prg_hi_next = mod_rem[PRG_W-1:0];
                        OP_CHR_LO: begin
                            if (cfg.chr_present) begin
                                chr_lo_next = mod_rem;
                            end
                        end
                        OP_CHR_HI: begin
                            if (cfg.chr_present) begin
                                chr_hi_next = regs.control[CTRL_CHR_MODE_BIT] ?
                                              mod_rem : chr_lo_reg + CHR_W'(1);
                            end
                        end
                        default: prg_lo_next = prg_lo_reg;
                    endcase
                    if (op_reg == OP_CHR_HI) begin
                        mirror_next = {~regs.control[1], regs.control[0]};
                        state_next = ST_DONE;
                    end else begin
                        op_next = op_t'(op_reg + 2'd1);
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_upd_next = commit_reg;
                    out_prg_lo_next = prg_lo_reg;
                    out_prg_hi_next = prg_hi_reg;
                    out_chr_lo_next = chr_lo_reg;
                    out_chr_hi_next = chr_hi_reg;
                    out_mirror_next = mirror_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_PRG_LO;
            commit_reg <= 1'b0;
            prg_lo_reg <= '0;
            prg_hi_reg <= '0;
            chr_lo_reg <= '0;
            chr_hi_reg <= '0;
            mirror_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            commit_reg <= commit_next;
            prg_lo_reg <= prg_lo_next;
            prg_hi_reg <= prg_hi_next;
            chr_lo_reg <= chr_lo_next;
            chr_hi_reg <= chr_hi_next;
            mirror_reg <= mirror_next;
            m_valid_reg <= m_valid_next;
        end
        out_upd_reg <= out_upd_next;
        out_prg_lo_reg <= out_prg_lo_next;
        out_prg_hi_reg <= out_prg_hi_next;
        out_chr_lo_reg <= out_chr_lo_next;
        out_chr_hi_reg <= out_chr_hi_next;
        out_mirror_reg <= out_mirror_next;
    end

    assign m_valid = m_valid_reg;
    assign m_mapping_updated = out_upd_reg;
    assign m_prg_bank_low = out_prg_lo_reg;
    assign m_prg_bank_high = out_prg_hi_reg;
    assign m_chr_bank_low = out_chr_lo_reg;
    assign m_chr_bank_high = out_chr_hi_reg;
    assign m_mirroring_mode = out_mirror_reg;

`ifndef SYNTHESIS
    a_done_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ST_WAIT)
        else $error("Remainder unit finished while the sequencer was not waiting.");

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && mod_done && mod_req.modulus != '0) |->
        mod_rem < mod_req.modulus)
        else $error("Remainder is not below its modulus.");

    a_last_op_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && mod_done && op_reg == OP_CHR_HI) |=>
        state_reg == ST_DONE)
        else $error("Sequencer did not finish after the last bank.");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("Sequencer stayed idle after taking a word.");

    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> (op_reg == OP_PRG_LO || commit_reg))
        else $error("Bank sequence ran for a word that committed nothing.");
`endif

endmodule

/* rtl/core/serial_loaded_bank_mapper_unit.sv */
// Top level of the serial loaded bank mapper with its configuration registers.
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_cpu_address, s_data_byte
//  m_       out        m_valid / m_ready      mapping_updated, banks, mirroring
//  cfg_     in         cfg_wr_en              cfg_index, cfg_data
//
// A word that commits no register passes from acceptance through ST_DONE to the output
// register. A committing word passes ST_START and ST_WAIT for each of four remainders on
// the shared remainder unit, which handles one numerator bit per cycle, then ST_DONE
// hands the result to the output register. The input is not ready while a word is in
// work; a result waiting on m_ready stalls only the hand-off to the output register.
// Synchronous reset clears the mapper registers, the held banks and restores the
// configuration defaults.
module serial_loaded_bank_mapper_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [slbm_pkg::ADDR_W-1:0]       s_cpu_address,
    input  logic [slbm_pkg::DATA_W-1:0]       s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_mapping_updated,
    output logic [slbm_pkg::PRG_W-1:0]        m_prg_bank_low,
    output logic [slbm_pkg::PRG_W-1:0]        m_prg_bank_high,
    output logic [slbm_pkg::CHR_W-1:0]        m_chr_bank_low,
    output logic [slbm_pkg::CHR_W-1:0]        m_chr_bank_high,
    output logic [slbm_pkg::MIRROR_W-1:0]     m_mirroring_mode,
    input  logic                              cfg_wr_en,
    input  logic [slbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import slbm_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    mregs_t            regs;
    mod_req_t          mod_req;
    logic              commit;
    logic              mod_done;
    logic [REM_W-1:0]  mod_rem;
    logic              load_en;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRG_PAGES:   cfg_next.prg_pages = cfg_data[PRG_CNT_W-1:0];
                CFG_CHR_PAGES:   cfg_next.chr_pages = cfg_data[CHR_CNT_W-1:0];
                CFG_CHR_PRESENT: cfg_next.chr_present = cfg_data[0];
                CFG_SIZE_MODE:   cfg_next.size_mode = cfg_data[CART_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prg_pages <= PRG_CNT_W'(16);
            cfg_reg.chr_pages <= CHR_CNT_W'(16);
            cfg_reg.chr_present <= 1'b1;
            cfg_reg.size_mode <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign load_en = s_valid && s_ready;

    slbm_loader u_loader (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_en     (load_en),
        .cpu_address (s_cpu_address),
        .data_byte   (s_data_byte),
        .commit      (commit),
        .regs        (regs)
    );

    slbm_mod_unit u_mod_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    slbm_sequencer u_sequencer (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .commit            (commit),
        .regs              (regs),
        .cfg               (cfg_reg),
        .mod_req           (mod_req),
        .mod_done          (mod_done),
        .mod_rem           (mod_rem),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mapping_updated (m_mapping_updated),
        .m_prg_bank_low    (m_prg_bank_low),
        .m_prg_bank_high   (m_prg_bank_high),
        .m_chr_bank_low    (m_chr_bank_low),
        .m_chr_bank_high   (m_chr_bank_high),
        .m_mirroring_mode  (m_mirroring_mode)
    );

endmodule
